// ----- rtl/prlt_pkg.sv -----
package prlt_pkg;

   localparam int WORD_WIDTH          = 32;
   localparam int OCC_WIDTH           = 4;
   localparam int TABLE_DEPTH_DEFAULT = 10;
   localparam int DIV_STEPS           = 32;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REPLY  = 1'b1
   } opcode_type;

   // one command at a time; all zero means hold
   typedef struct packed {
      logic compare;
      logic sweep;
      logic shift;
      logic insert;
   } cell_ctrl_type;

endpackage

// ----- rtl/pending_request_latency_tracker.sv -----
// Each insert item passes S_INSERT then S_RESP. A reply item passes S_COMPARE,
// S_SWEEP over every cell and S_SHIFT; with a match S_MUL, S_ADD, S_DIV follow.
// One item at a time: the search ripples through the cell row one cell per
// cycle and the mean update runs a 32-step restoring divider.
// A new item is taken only in S_IDLE, after the last result. The receiver cannot stall.
// Synchronous reset empties the table and zeroes the mean and all counts.
module pending_request_latency_tracker
   import prlt_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_opcode,
   input  logic [WORD_WIDTH-1:0] req_request_id,
   input  logic                  req_accepted_flag,
   input  logic [WORD_WIDTH-1:0] req_now_ms,
   output logic                  rsp_valid,
   output logic                  rsp_stored,
   output logic                  rsp_match_found,
   output logic [WORD_WIDTH-1:0] rsp_latency_ms,
   output logic [WORD_WIDTH-1:0] rsp_mean_latency_ms,
   output logic [WORD_WIDTH-1:0] rsp_reply_total,
   output logic [WORD_WIDTH-1:0] rsp_positive_total,
   output logic [WORD_WIDTH-1:0] rsp_negative_total,
   output logic [OCC_WIDTH-1:0]  rsp_occupancy
);

   localparam int COUNT_WIDTH = $clog2(TABLE_DEPTH + 1);
   localparam logic [COUNT_WIDTH-1:0] FULL_COUNT = COUNT_WIDTH'(TABLE_DEPTH);
   localparam logic [COUNT_WIDTH-1:0] LAST_SWEEP = COUNT_WIDTH'(TABLE_DEPTH - 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_INSERT,
      S_COMPARE,
      S_SWEEP,
      S_SHIFT,
      S_MUL,
      S_ADD,
      S_DIV,
      S_RESP
   } state_type;

   state_type             state_ff;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] sweep_ff;
   logic                  op_ff;
   logic                  flag_ff;
   logic [WORD_WIDTH-1:0] key_id_ff;
   logic [WORD_WIDTH-1:0] key_time_ff;
   logic [WORD_WIDTH-1:0] mean_ff;
   logic [WORD_WIDTH-1:0] reply_ff;
   logic [WORD_WIDTH-1:0] pos_ff;
   logic [WORD_WIDTH-1:0] neg_ff;
   logic [WORD_WIDTH-1:0] n_ff;
   logic [WORD_WIDTH-1:0] lat_ff;
   logic                  stored_ff;
   logic                  match_ff;
   logic [2*WORD_WIDTH-1:0] prod_ff;
   logic [2*WORD_WIDTH-1:0] prod_in;
   logic [2*WORD_WIDTH-1:0] num_in;
   logic [WORD_WIDTH:0]   divisor;
   logic                  div_done;
   logic [WORD_WIDTH-1:0] div_quo;
   cell_ctrl_type         ctrl;

   logic [WORD_WIDTH-1:0] cell_id    [TABLE_DEPTH];
   logic [WORD_WIDTH-1:0] cell_time  [TABLE_DEPTH];
   logic                  cell_found [TABLE_DEPTH];
   logic [WORD_WIDTH-1:0] cell_carry [TABLE_DEPTH];

   always_comb begin
      ctrl         = '0;
      ctrl.insert  = (state_ff == S_INSERT) && (count_ff < FULL_COUNT);
      ctrl.compare = (state_ff == S_COMPARE);
      ctrl.sweep   = (state_ff == S_SWEEP);
      ctrl.shift   = (state_ff == S_SHIFT);
   end

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      logic                  left_found;
      logic [WORD_WIDTH-1:0] left_time;
      logic [WORD_WIDTH-1:0] right_id;
      logic [WORD_WIDTH-1:0] right_time;

      if (i == 0) begin : g_head
         assign left_found = 1'b0;
         assign left_time  = '0;
      end else begin : g_body
         assign left_found = cell_found[i-1];
         assign left_time  = cell_carry[i-1];
      end

      // the slot past the end is dropped by the count decrement
      if (i == TABLE_DEPTH - 1) begin : g_tail
         assign right_id   = '0;
         assign right_time = '0;
      end else begin : g_next
         assign right_id   = cell_id[i+1];
         assign right_time = cell_time[i+1];
      end

      prlt_cell #(
         .CELL_INDEX  (i),
         .COUNT_WIDTH (COUNT_WIDTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .count      (count_ff),
         .key_id     (key_id_ff),
         .key_time   (key_time_ff),
         .left_found (left_found),
         .left_time  (left_time),
         .right_id   (right_id),
         .right_time (right_time),
         .id_out     (cell_id[i]),
         .time_out   (cell_time[i]),
         .found_out  (cell_found[i]),
         .carry_out  (cell_carry[i])
      );
   end

   assign prod_in = mean_ff * n_ff;
   assign num_in  = prod_ff + {{WORD_WIDTH{1'b0}}, lat_ff};
   assign divisor = {1'b0, n_ff} + 1'b1;

   prlt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == S_ADD),
      .dividend (num_in),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         sweep_ff <= '0;
         mean_ff  <= '0;
         reply_ff <= '0;
         pos_ff   <= '0;
         neg_ff   <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  op_ff       <= req_opcode;
                  flag_ff     <= req_accepted_flag;
                  key_id_ff   <= req_request_id;
                  key_time_ff <= req_now_ms;
                  state_ff    <= (req_opcode == OP_REPLY) ? S_COMPARE : S_INSERT;
               end
            end
            S_INSERT: begin
               stored_ff <= (count_ff < FULL_COUNT);
               match_ff  <= 1'b0;
               lat_ff    <= '0;
               if (count_ff < FULL_COUNT) begin
                  count_ff <= count_ff + 1'b1;
               end
               state_ff <= S_RESP;
            end
            S_COMPARE: begin
               sweep_ff <= '0;
               state_ff <= S_SWEEP;
            end
            S_SWEEP: begin
               sweep_ff <= sweep_ff + 1'b1;
               if (sweep_ff == LAST_SWEEP) begin
                  state_ff <= S_SHIFT;
               end
            end
            S_SHIFT: begin
               stored_ff <= 1'b0;
               match_ff  <= cell_found[TABLE_DEPTH-1];
               // carry holds the send time of the oldest hit; elapsed wraps at 32 bits
               lat_ff    <= cell_found[TABLE_DEPTH-1] ?
                            key_time_ff - cell_carry[TABLE_DEPTH-1] : '0;
               n_ff      <= reply_ff;
               reply_ff  <= reply_ff + 1'b1;
               if (flag_ff) begin
                  pos_ff <= pos_ff + 1'b1;
               end else begin
                  neg_ff <= neg_ff + 1'b1;
               end
               if (cell_found[TABLE_DEPTH-1]) begin
                  count_ff <= count_ff - 1'b1;
                  state_ff <= S_MUL;
               end else begin
                  state_ff <= S_RESP;
               end
            end
            S_MUL: begin
               prod_ff  <= prod_in;
               state_ff <= S_ADD;
            end
            S_ADD: begin
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (div_done) begin
                  mean_ff  <= div_quo;
                  state_ff <= S_RESP;
               end
            end
            S_RESP: begin
               state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy                = (state_ff != S_IDLE);
   assign rsp_valid           = (state_ff == S_RESP);
   assign rsp_stored          = stored_ff;
   assign rsp_match_found     = match_ff;
   assign rsp_latency_ms      = lat_ff;
   assign rsp_mean_latency_ms = mean_ff;
   assign rsp_reply_total     = reply_ff;
   assign rsp_positive_total  = pos_ff;
   assign rsp_negative_total  = neg_ff;
   assign rsp_occupancy       = OCC_WIDTH'(count_ff);

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("table count past depth");

   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held");

   a_kind_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_stored && rsp_match_found))
      else $error("item both stored and matched");

   a_nomatch_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_match_found |-> rsp_latency_ms == '0)
      else $error("latency without match");

   a_op_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (op_ff == OP_INSERT) |-> !rsp_match_found)
      else $error("insert reported a match");
`endif

endmodule

// ----- rtl/prlt_cell.sv -----
module prlt_cell
   import prlt_pkg::*;
#(
   parameter int CELL_INDEX  = 0,
   parameter int COUNT_WIDTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cell_ctrl_type          ctrl,
   input  logic [COUNT_WIDTH-1:0] count,
   input  logic [WORD_WIDTH-1:0]  key_id,
   input  logic [WORD_WIDTH-1:0]  key_time,
   input  logic                   left_found,
   input  logic [WORD_WIDTH-1:0]  left_time,
   input  logic [WORD_WIDTH-1:0]  right_id,
   input  logic [WORD_WIDTH-1:0]  right_time,
   output logic [WORD_WIDTH-1:0]  id_out,
   output logic [WORD_WIDTH-1:0]  time_out,
   output logic                   found_out,
   output logic [WORD_WIDTH-1:0]  carry_out
);

   localparam logic [COUNT_WIDTH-1:0] MY_INDEX = COUNT_WIDTH'(CELL_INDEX);

   logic [WORD_WIDTH-1:0] id_ff;
   logic [WORD_WIDTH-1:0] time_ff;
   logic [WORD_WIDTH-1:0] carry_ff;
   logic                  hit_ff;
   logic                  found_ff;
   logic                  occupied;

   assign occupied = (count > MY_INDEX);

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff   <= 1'b0;
         found_ff <= 1'b0;
      end else if (ctrl.compare) begin
         hit_ff   <= occupied && (id_ff == key_id);
         found_ff <= 1'b0;
      end else if (ctrl.sweep) begin
         // during a sweep found travels right one cell per cycle; oldest hit keeps priority
         found_ff <= left_found | hit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.compare) begin
         carry_ff <= '0;
      end else if (ctrl.sweep) begin
         if (left_found) begin
            carry_ff <= left_time;
         end else if (hit_ff) begin
            carry_ff <= time_ff;
         end else begin
            carry_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift && found_ff) begin
         id_ff   <= right_id;
         time_ff <= right_time;
      end else if (ctrl.insert && (count == MY_INDEX)) begin
         id_ff   <= key_id;
         time_ff <= key_time;
      end
   end

   assign id_out    = id_ff;
   assign time_out  = time_ff;
   assign found_out = found_ff;
   assign carry_out = carry_ff;

endmodule

// ----- rtl/prlt_div.sv -----
module prlt_div
   import prlt_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [2*WORD_WIDTH-1:0]   dividend,
   input  logic [WORD_WIDTH:0]       divisor,
   output logic                      done,
   output logic [WORD_WIDTH-1:0]     quotient
);

   localparam int STEP_WIDTH = $clog2(DIV_STEPS);
   localparam logic [STEP_WIDTH-1:0] LAST_STEP = STEP_WIDTH'(DIV_STEPS - 1);

   logic [WORD_WIDTH:0]   rem_ff;
   logic [WORD_WIDTH-1:0] quo_ff;
   logic [WORD_WIDTH:0]   div_ff;
   logic [STEP_WIDTH-1:0] step_ff;
   logic                  run_ff;
   logic                  done_ff;
   logic [WORD_WIDTH+1:0] trial;
   logic [WORD_WIDTH+1:0] diff;
   logic                  take;

   assign trial = {rem_ff, quo_ff[WORD_WIDTH-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign take  = (trial >= {1'b0, div_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            step_ff <= '0;
         end else if (run_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // quotient fits one word since the upper half starts below the divisor
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= {1'b0, dividend[2*WORD_WIDTH-1:WORD_WIDTH]};
         quo_ff <= dividend[WORD_WIDTH-1:0];
         div_ff <= divisor;
      end else if (run_ff) begin
         rem_ff <= take ? diff[WORD_WIDTH:0] : trial[WORD_WIDTH:0];
         quo_ff <= {quo_ff[WORD_WIDTH-2:0], take};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
